// ===== sv/cerl_pkg.sv =====
`timescale 1ns / 1ps
// cerl_pkg: shared types, constants and the log2 fraction table for the
// cross entropy row loss unit; no dependencies

package cerl_pkg;

  // classes per row are clamped to this bound
  localparam int MAX_CLASSES     = 1024;
  // entries in the log2 mantissa table
  localparam int LOG_TABLE_DEPTH = 256;
  // ln2 in Q0.16
  localparam int LN2_Q16         = 45426;
  // entries in the queue between front and back
  localparam int QUEUE_DEPTH     = 4;

  localparam int CLASS_W = 11;
  localparam int PROB_W  = 16;
  localparam int LOSS_W  = 32;
  localparam int POS_W   = 4;
  localparam int FRAC_W  = 15;
  localparam int IDX_W   = $clog2(LOG_TABLE_DEPTH);
  localparam int NL2_W   = 21;
  localparam int NLN_W   = 20;
  localparam int TERM_W  = 20;

  typedef struct packed {
    logic [PROB_W-1:0] probability;
    logic [PROB_W-1:0] target;
    logic              batch_end;
  } cerl_in_t;

  typedef struct packed {
    logic [LOSS_W-1:0] row_loss;
    logic              final_row;
  } cerl_out_t;

  // classified beat handed from front to back
  typedef struct packed {
    logic [POS_W-1:0]  lead_pos;
    logic [PROB_W-1:0] log_frac;
    logic [PROB_W-1:0] target;
    logic              batch_end;
  } cerl_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cerl_qstat_t;

  typedef logic [PROB_W-1:0] log_tab_t [LOG_TABLE_DEPTH];

  // log2(1 + i/depth) in Q0.16 by repeated squaring, evaluated at elaboration
  function automatic log_tab_t build_log_tab();
    log_tab_t    tab;
    logic [63:0] x;
    logic [15:0] r;
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      x = (64'd1 << 30) + ((64'(i) << 30) / 64'(LOG_TABLE_DEPTH));
      r = '0;
      for (int k = 0; k < 16; k++) begin
        x = (x * x) >> 30;
        r = {r[14:0], 1'b0};
        if (x >= (64'd2 << 30)) begin
          r[0] = 1'b1;
          x = x >> 1;
        end
      end
      tab[i] = r;
    end
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

// ===== sv/cerl_front.sv =====
`timescale 1ns / 1ps
// cerl_front: accepts input beats, clamps the probability, finds the leading
// one and looks up the log2 mantissa; depends on cerl_pkg

module cerl_front import cerl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  cerl_in_t    item,
  input  cerl_qstat_t qstat,
  output logic        push,
  output cerl_item_t  push_item
);

  localparam int PROD_W = FRAC_W + $clog2(LOG_TABLE_DEPTH + 1);

  logic              slot_valid;
  cerl_item_t        slot;
  logic              accept;
  logic [PROB_W-1:0] p;
  logic [POS_W-1:0]  lead;
  logic [30:0]       shifted;
  logic [FRAC_W-1:0] frac;
  logic [PROD_W-1:0] idx_prod;
  logic [PROD_W-FRAC_W-1:0] idx_full;
  logic [IDX_W-1:0]  idx;

  assign push       = slot_valid && !qstat.full;
  assign item_stall = slot_valid && qstat.full;
  assign accept     = item_valid && !item_stall;
  assign push_item  = slot;

  always_comb begin
    // zero stands in for the smallest probability
    p = (item.probability == '0) ? PROB_W'(1) : item.probability;
    lead = '0;
    for (int i = 0; i < PROB_W; i++) begin
      if (p[i]) begin
        lead = POS_W'(i);
      end
    end
    shifted  = 31'(p) << (4'd15 - lead);
    frac     = shifted[FRAC_W-1:0];
    idx_prod = PROD_W'(frac) * PROD_W'(LOG_TABLE_DEPTH);
    idx_full = idx_prod[PROD_W-1:FRAC_W];
    if (32'(idx_full) >= 32'(LOG_TABLE_DEPTH)) begin
      idx = IDX_W'(LOG_TABLE_DEPTH - 1);
    end else begin
      idx = IDX_W'(idx_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (accept) begin
      slot_valid <= 1'b1;
    end else if (push) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot.lead_pos  <= lead;
      slot.log_frac  <= LOG_TAB[idx];
      slot.target    <= item.target;
      slot.batch_end <= item.batch_end;
    end
  end

endmodule

// ===== sv/cerl_queue.sv =====
`timescale 1ns / 1ps
// cerl_queue: short first-in first-out buffer of classified beats between
// front and back; depends on cerl_pkg

module cerl_queue import cerl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  cerl_item_t  push_item,
  input  logic        pop,
  output cerl_item_t  head,
  output cerl_qstat_t qstat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cerl_item_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign head        = slots[rd_ptr];
  assign qstat.full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule

// ===== sv/cerl_back.sv =====
`timescale 1ns / 1ps
// cerl_back: sequencer that scales the log term, weights it by the label,
// accumulates the row sum and registers the row result; depends on cerl_pkg

module cerl_back import cerl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [CLASS_W-1:0] class_count,
  input  cerl_item_t         head,
  input  cerl_qstat_t        qstat,
  output logic               pop,
  output logic               loss_valid,
  input  logic               loss_stall,
  output cerl_out_t          loss
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LN,
    S_TERM,
    S_ACC
  } state_t;

  state_t             state;
  logic [NL2_W-1:0]   nl2;
  logic [NLN_W-1:0]   nln;
  logic [TERM_W-1:0]  term;
  logic [PROB_W-1:0]  tgt;
  logic               last;
  logic [CLASS_W-1:0] class_index;
  logic [LOSS_W-1:0]  loss_sum;

  logic [CLASS_W-1:0] count;
  logic               row_done;
  logic               out_busy;
  logic               emit;
  logic [36:0]        ln_prod;
  logic [35:0]        term_prod;
  logic [LOSS_W:0]    sum_wide;
  logic [LOSS_W-1:0]  sum_sat;
  logic [NL2_W-1:0]   nl2_next;

  assign pop      = (state == S_IDLE) && !qstat.empty;
  assign out_busy = loss_valid && loss_stall;
  // a row result is loaded into the output register this cycle
  assign emit     = (state == S_ACC) && row_done && !out_busy;

  always_comb begin
    priority if (class_count == '0) begin
      count = CLASS_W'(1);
    end else if (32'(class_count) > 32'(MAX_CLASSES)) begin
      count = CLASS_W'(MAX_CLASSES);
    end else begin
      count = class_count;
    end
    row_done  = (12'(class_index) + 12'd1) >= 12'(count);
    nl2_next  = (NL2_W'(5'd16 - 5'(head.lead_pos)) << 16) - NL2_W'(head.log_frac);
    ln_prod   = 37'(nl2) * 37'(LN2_Q16) + 37'(32768);
    term_prod = 36'(nln) * 36'(tgt);
    sum_wide  = (LOSS_W+1)'(loss_sum) + (LOSS_W+1)'(term);
    sum_sat   = sum_wide[LOSS_W] ? '1 : sum_wide[LOSS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      loss_valid  <= 1'b0;
      class_index <= '0;
      loss_sum    <= '0;
    end else begin
      if (loss_valid && !loss_stall && !emit) begin
        loss_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!qstat.empty) begin
            nl2   <= nl2_next;
            tgt   <= head.target;
            last  <= head.batch_end;
            state <= S_LN;
          end
        end
        S_LN: begin
          nln   <= ln_prod[16+NLN_W-1:16];
          state <= S_TERM;
        end
        S_TERM: begin
          term  <= term_prod[16+TERM_W-1:16];
          state <= S_ACC;
        end
        S_ACC: begin
          if (row_done) begin
            // hold until the previous row result has left
            if (!out_busy) begin
              loss_valid     <= 1'b1;
              loss.row_loss  <= sum_sat;
              loss.final_row <= last;
              loss_sum       <= '0;
              class_index    <= '0;
              state          <= S_IDLE;
            end
          end else begin
            loss_sum    <= sum_sat;
            class_index <= class_index + 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_row_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && row_done && !out_busy) |=> (loss_sum == '0 && class_index == '0))
    else $error("row sum not cleared after row result");

  a_wait_on_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && row_done && out_busy) |=> (state == S_ACC && loss_valid))
    else $error("row result overwrote a waiting result");

endmodule

// ===== sv/cross_entropy_row_loss_unit.sv =====
`timescale 1ns / 1ps
// cross_entropy_row_loss_unit: top level, holds the class count register and
// joins front, queue and back; depends on cerl_pkg and the cerl modules

// Streams one (probability, label) beat per class, both unsigned Q0.16, and
// returns one unsigned Q16.16 saturating cross entropy per row once
// class_count beats have been taken (a count of zero acts as one, a count
// above 1024 acts as 1024). A zero probability is treated as one LSB. The
// front takes a beat in any cycle its holding register is free, clamps the
// probability, finds the leading one and reads the 256-entry log2 mantissa
// table; a four-entry queue decouples it from the back. The back is a
// four-step sequencer (log2 assembly, ln2 scale multiply, label multiply,
// saturating accumulate) that takes a new beat only after it has finished
// the last one; short bursts of up to six beats are absorbed by the front
// register, queue and back at one per cycle. A row result sits in an output
// register while the next row proceeds; the back waits only when a second
// row result is ready before the first was taken. A row's last beat passes
// through the front register, the queue, the back's steps and the output
// register before its result appears. class_count may be written only while
// the unit is idle; writes do not clear a row in progress.

module cross_entropy_row_loss_unit import cerl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CLASS_W-1:0] cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  cerl_in_t           item,
  output logic               loss_valid,
  input  logic               loss_stall,
  output cerl_out_t          loss
);

  // classes per row, reset to one
  logic [CLASS_W-1:0] class_count;

  // front to queue
  logic        push;
  cerl_item_t  push_item;

  // queue to back
  logic        pop;
  cerl_item_t  head;
  cerl_qstat_t qstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= CLASS_W'(1);
    end else if (cfg_write) begin
      class_count <= cfg_data;
    end
  end

  // classify and look up the log mantissa
  cerl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .qstat      (qstat),
    .push       (push),
    .push_item  (push_item)
  );

  // decoupling buffer
  cerl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // scale, weight, accumulate and emit the row beat
  cerl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .class_count (class_count),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .loss_valid  (loss_valid),
    .loss_stall  (loss_stall),
    .loss        (loss)
  );

endmodule

// ===== test/cerl_loss_checker.sv =====
`timescale 1ns / 1ps
// cerl_loss_checker: row loss predictor and scoreboard for the cross entropy
// row loss unit; watches the config port and both channels, depends on cerl_pkg

module cerl_loss_checker import cerl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CLASS_W-1:0] cfg_data,
  input  logic               item_valid,
  input  logic               item_stall,
  input  cerl_in_t           item,
  input  logic               loss_valid,
  input  logic               loss_stall,
  input  cerl_out_t          loss,
  output logic [31:0]        errors,
  output logic [31:0]        pending
);

  logic [15:0]        log2_mant [LOG_TABLE_DEPTH];
  logic [CLASS_W-1:0] row_classes;
  int                 row_pos;
  logic [31:0]        row_sum;
  cerl_out_t          row_loss_q [$];

  // log2(1 + slot/depth) in Q0.16, one bit per squaring round
  function automatic logic [15:0] mant_log2(int slot);
    logic [63:0] x;
    logic [15:0] bits;
    x = (64'd1 << 30) + ((64'(slot) << 30) / LOG_TABLE_DEPTH);
    bits = '0;
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 30;
      bits = bits << 1;
      if (x >= (64'd1 << 31)) begin
        bits[0] = 1'b1;
        x = x >> 1;
      end
    end
    return bits;
  endfunction

  // -ln(prob) in Q4.16, zero probability taken as one lsb
  function automatic logic [19:0] neg_ln_q416(logic [15:0] prob);
    logic [15:0] p;
    logic [15:0] norm;
    int          lead;
    logic [31:0] slot;
    logic [20:0] nl2;
    logic [63:0] scaled;
    p = (prob == '0) ? 16'd1 : prob;
    lead = 0;
    for (int i = 0; i < 16; i++)
      if (p[i]) lead = i;
    norm = p << (15 - lead);
    slot = (32'(norm[14:0]) * LOG_TABLE_DEPTH) >> 15;
    if (slot >= LOG_TABLE_DEPTH) slot = LOG_TABLE_DEPTH - 1;
    nl2 = (21'(16 - lead) << 16) - 21'(log2_mant[slot]);
    scaled = (64'(nl2) * LN2_Q16 + 64'd32768) >> 16;
    return scaled[19:0];
  endfunction

  initial begin
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) log2_mant[i] = mant_log2(i);
    errors = '0;
    pending = '0;
    row_classes = 1;
    row_pos = 0;
    row_sum = '0;
  end

  always @(posedge clk) begin
    logic [31:0] term;
    logic [32:0] acc;
    int          limit;
    cerl_out_t   want;
    if (rst) begin
      row_classes = 1;
      row_pos = 0;
      row_sum = '0;
      row_loss_q.delete();
    end else begin
      if (cfg_write) row_classes = cfg_data;

      if (item_valid && !item_stall) begin
        term = 32'((64'(neg_ln_q416(item.probability)) * item.target) >> 16);
        acc = 33'(row_sum) + 33'(term);
        row_sum = acc[32] ? '1 : acc[31:0];
        limit = (row_classes == 0) ? 1 :
                (row_classes > MAX_CLASSES) ? MAX_CLASSES : int'(row_classes);
        if (row_pos + 1 >= limit) begin
          row_loss_q.push_back({row_sum, item.batch_end});
          row_sum = '0;
          row_pos = 0;
        end else begin
          row_pos++;
        end
      end

      if (loss_valid && !loss_stall) begin
        if (row_loss_q.size() == 0) begin
          $display("%0t unexpected row loss beat: actual %h", $time, loss);
          errors++;
        end else begin
          want = row_loss_q.pop_front();
          if (loss.row_loss !== want.row_loss) begin
            $display("%0t row_loss expected %h actual %h", $time, want.row_loss,
                     loss.row_loss);
            errors++;
          end
          if (loss.final_row !== want.final_row) begin
            $display("%0t final_row expected %b actual %b", $time, want.final_row,
                     loss.final_row);
            errors++;
          end
        end
      end
    end
    pending = row_loss_q.size();
  end

endmodule

// ===== test/cross_entropy_row_loss_unit_tb.sv =====
`timescale 1ns / 1ps
// cross_entropy_row_loss_unit_tb: stimulus and verdict for the cross entropy
// row loss unit; depends on cerl_pkg, the unit and cerl_loss_checker

module cross_entropy_row_loss_unit_tb;
  import cerl_pkg::*;

  // cycles with no beat on either channel before the run is given up
  localparam int STALL_LIMIT = 2000;
  // quiet time before a config write, covers beats still in the pipe
  localparam int SETTLE      = 40;
  // long receiver hold-off so the queue and front register fill up
  localparam int HOLD_CYCLES = 300;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               cfg_write  = 1'b0;
  logic [CLASS_W-1:0] cfg_data   = '0;
  logic               item_valid = 1'b0;
  logic               item_stall;
  cerl_in_t           item       = '0;
  logic               loss_valid;
  logic               loss_stall = 1'b0;
  cerl_out_t          loss;

  logic [31:0] errors;
  logic [31:0] pending;
  int          snd_idle     = 0;
  int          rcv_idle     = 0;
  bit          hold_req     = 1'b0;
  int          quiet_cycles = 0;

  cross_entropy_row_loss_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .loss_valid(loss_valid),
    .loss_stall(loss_stall),
    .loss      (loss)
  );

  cerl_loss_checker loss_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .loss_valid(loss_valid),
    .loss_stall(loss_stall),
    .loss      (loss),
    .errors    (errors),
    .pending   (pending)
  );

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog: any accepted beat on either side restarts the count
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (loss_valid && !loss_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("cross_entropy_row_loss_unit_tb: errors");
      $finish;
    end
  end

  // receiver side: random stalls, or a long hold-off when one is requested
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        loss_stall <= 1'b1;
        hold_left--;
      end else begin
        loss_stall <= ($urandom_range(99) < rcv_idle);
      end
    end
  end

  // probabilities spread over every leading-one position, plus the extremes
  function automatic logic [15:0] rand_prob();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(65535) >> $urandom_range(15));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // one input beat; valid stays high into the next beat unless a gap is drawn
  task automatic send_beat(input logic [15:0] prob, input logic [15:0] weight,
                           input logic last);
    while ($urandom_range(99) < snd_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= {prob, weight, last};
    do @(posedge clk); while (item_stall);
  endtask

  // class_count is written only with the unit drained and quiet
  task automatic set_class_count(input logic [CLASS_W-1:0] value);
    item_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // one row of random beats; batch_end follows the row, with a little noise
  task automatic send_row(input int classes, input logic last);
    for (int i = 0; i < classes; i++)
      send_beat(rand_prob(), rand_weight(), ($urandom_range(19) == 0) ? ~last : last);
  endtask

  initial begin
    int counts [9];
    int classes;
    int rows;

    counts = '{1, 3, 7, 2, 5, 16, 0, 4, 11};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: reset count of one, so every beat closes a row
    send_beat(16'h0000, 16'hFFFF, 1'b1);   // zero probability clamps to one lsb
    send_beat(16'hFFFF, 16'hFFFF, 1'b0);
    send_beat(16'h0001, 16'h0000, 1'b0);
    send_beat(16'h8000, 16'h8000, 1'b1);
    send_beat(16'h0001, 16'hFFFF, 1'b0);
    send_beat(16'h00FF, 16'h1234, 1'b1);
    send_beat(16'h7FFF, 16'hFFFF, 1'b0);

    // count of zero behaves as one
    set_class_count('0);
    send_beat(16'h0100, 16'hFFFF, 1'b0);
    send_beat(16'h0003, 16'h8001, 1'b1);

    // count lowered in the middle of a row: next beat closes it
    set_class_count(11'd8);
    send_beat(16'h4000, 16'hFFFF, 1'b0);
    send_beat(16'h0000, 16'hFFFF, 1'b0);
    send_beat(16'h1234, 16'h5678, 1'b0);
    send_beat(16'h0010, 16'hABCD, 1'b0);
    send_beat(16'hFFFF, 16'h0001, 1'b0);
    set_class_count(11'd3);
    send_beat(16'h0800, 16'hFFFF, 1'b1);

    set_class_count(11'd2);
    send_beat(16'hC000, 16'h4000, 1'b0);
    send_beat(16'h0002, 16'hFFFF, 1'b1);
    send_beat(16'hFFFE, 16'h0001, 1'b1);
    send_beat(16'h0000, 16'h0000, 1'b0);

    // random rows: light sender gaps and heavy receiver stalls, then the
    // reverse, then none; the first phase without idling starts with the
    // receiver held off while one-beat rows keep coming
    for (int ph = 0; ph < 9; ph++) begin
      snd_idle = (ph < 3) ? 7 : (ph < 6) ? 47 : 0;
      rcv_idle = (ph < 3) ? 47 : (ph < 6) ? 7 : 0;
      set_class_count(11'(counts[ph]));
      if (ph == 6) hold_req = 1'b1;
      classes = (counts[ph] == 0) ? 1 : counts[ph];
      rows = 50 / classes + 1;
      for (int r = 0; r < rows; r++)
        send_row(classes, $urandom_range(3) == 0);
    end

    // count above the bound, then lowered so the next beat closes the row
    set_class_count('1);
    send_row(20, 1'b0);
    set_class_count(11'd3);
    send_beat(16'h2000, 16'hFFFF, 1'b1);

    // drain, then give the pipe time to show any stray beat
    item_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("cross_entropy_row_loss_unit_tb: clean");
    end else begin
      $display("cross_entropy_row_loss_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/cerl_pkg.sv
sv/cerl_front.sv
sv/cerl_queue.sv
sv/cerl_back.sv
sv/cross_entropy_row_loss_unit.sv
test/cerl_loss_checker.sv
test/cross_entropy_row_loss_unit_tb.sv
